// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the walker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, held off during reset.
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of i_clk, reset included.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/gdw_pkg.sv =====
// Types, codes and neighbour offset tables for the grid walker.
// Depends on nothing; used by grid_dfs_walker and the testbench.
package gdw_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_EVAL,
        ST_DECIDE,
        ST_LOAD
    } t_state;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] KIND_OPEN    = 2'd0;
    localparam logic [1:0] KIND_WALL    = 2'd1;
    localparam logic [1:0] KIND_VISITED = 2'd2;
    localparam logic [1:0] KIND_TARGET  = 2'd3;

    localparam logic [2:0] STAT_ACK      = 3'd0;
    localparam logic [2:0] STAT_TARGET   = 3'd1;
    localparam logic [2:0] STAT_OPEN     = 3'd2;
    localparam logic [2:0] STAT_BACK     = 3'd3;
    localparam logic [2:0] STAT_NO_ROUTE = 3'd4;

    localparam int TRAIL_MAX = 16384;
    localparam int TRAIL_AW  = 14;
    localparam int DEPTH_W   = 15;
    localparam int CNT_W     = 14;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Row offset of neighbour k, in the order N, NE, E, SE, S, SW, W, NW
    function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
        logic signed [1:0] d;
        unique case (k)
            3'd0, 3'd1, 3'd7: d = -2'sd1;
            3'd2, 3'd6:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // Column offset of neighbour k
    function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
        logic signed [1:0] d;
        unique case (k)
            3'd0, 3'd4:       d = 2'sd0;
            3'd1, 3'd2, 3'd3: d = 2'sd1;
            default:          d = -2'sd1;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/grid_dfs_walker.sv =====
// Depth-first grid walker: grid memory, trail stack memory and step sequencer.
// Depends on gdw_pkg and assert_macros.svh.
//
// Usage
//   Commands enter on start while busy is low: write a cell, start a walk
//   at row 1 and column start_col, or take one step. Every command gives
//   one result beat on o_valid, a single cycle wide; the receiver cannot
//   stall it, so it must take the beat in that cycle.
//   Cell write, start and unused commands answer in the cycle after entry,
//   as does a step with an empty trail. A step scans the eight neighbours
//   in turn, each through an issue and an eval state, as the grid memory
//   read is registered; a decide state picks the move, and a back-up then
//   passes a load state for the registered trail memory read. One command
//   is in flight at a time. The user writes start_col through i_cfg_we /
//   i_cfg_data only while idle; the block itself does not enforce it.
//   After reset the block clears the grid memory to open, one cell per
//   cycle, all GRID_ROWS x GRID_COLS cells (capped at 128 each), with busy
//   high; configuration writes are taken during that time.
`include "assert_macros.svh"

module grid_dfs_walker #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_cell_row,
    input  logic [6:0]  i_cell_col,
    input  logic [1:0]  i_cell_kind,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [6:0]  o_walker_row,
    output logic [6:0]  o_walker_col,
    output logic [13:0] o_step_count,
    output logic [2:0]  o_status
);

    localparam int ER    = (GRID_ROWS < 128) ? GRID_ROWS : 128;
    localparam int EC    = (GRID_COLS < 128) ? GRID_COLS : 128;
    localparam int CELLS = ER * EC;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = 7 + 7 + gdw_pkg::CNT_W;

    gdw_pkg::t_state r_state, n_state;

    // grid and trail memories
    logic [1:0]    grid_mem [CELLS];
    logic [SW-1:0] trail_mem [gdw_pkg::TRAIL_MAX];
    logic [1:0]    r_grid_rd;
    logic [SW-1:0] r_trail_rd;

    logic                        w_grid_we;
    logic [AW-1:0]               w_grid_waddr, w_grid_raddr;
    logic [1:0]                  w_grid_wdata;
    logic                        w_trail_we;
    logic [gdw_pkg::TRAIL_AW-1:0] w_trail_waddr, w_trail_raddr;
    logic [SW-1:0]               w_trail_wdata;

    // walker state
    logic [6:0]                   r_row, n_row, r_col, n_col, r_start_col;
    logic [gdw_pkg::CNT_W-1:0]    r_count, n_count;
    logic [gdw_pkg::DEPTH_W-1:0]  r_depth, n_depth;
    logic                         r_no_route, n_no_route;
    logic                         r_valid, n_valid;
    logic [2:0]                   r_status, n_status;
    logic [AW-1:0]                r_clr, n_clr;

    // scan state
    logic [2:0] r_k, n_k, r_tgt_k, n_tgt_k, r_free_k, n_free_k;
    logic       r_tgt_hit, n_tgt_hit, r_free_hit, n_free_hit, r_nb_in, n_nb_in;

    logic                 w_accept, w_can_step, w_walker_in, w_cell_in, w_nb_in;
    logic signed [7:0]    w_nr, w_nc, w_mr, w_mc;
    logic [1:0]           w_kind;
    logic [2:0]           w_pick;
    logic                 w_any;
    logic [gdw_pkg::TRAIL_AW-1:0] w_slot;
    logic [gdw_pkg::CNT_W-1:0]    w_inc;

    function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
        return AW'(int'(r) * EC + int'(c));
    endfunction

    function automatic logic on_grid(input logic signed [7:0] r, input logic signed [7:0] c);
        return !r[7] && !c[7] && ({1'b0, r[6:0]} < 8'(ER)) && ({1'b0, c[6:0]} < 8'(EC));
    endfunction

    assign w_accept    = start && !busy;
    assign w_can_step  = (r_depth != '0) && !r_no_route;
    assign w_walker_in = on_grid({1'b0, r_row}, {1'b0, r_col});
    assign w_cell_in   = on_grid({1'b0, i_cell_row}, {1'b0, i_cell_col});

    // neighbour under scan
    assign w_nr    = $signed({1'b0, r_row}) + 8'(gdw_pkg::nb_dr(r_k));
    assign w_nc    = $signed({1'b0, r_col}) + 8'(gdw_pkg::nb_dc(r_k));
    assign w_nb_in = on_grid(w_nr, w_nc);
    assign w_kind  = r_nb_in ? r_grid_rd : gdw_pkg::KIND_WALL;

    // chosen move
    assign w_pick = r_tgt_hit ? r_tgt_k : r_free_k;
    assign w_any  = r_tgt_hit || r_free_hit;
    assign w_mr   = $signed({1'b0, r_row}) + 8'(gdw_pkg::nb_dr(w_pick));
    assign w_mc   = $signed({1'b0, r_col}) + 8'(gdw_pkg::nb_dc(w_pick));
    assign w_inc  = (r_count == gdw_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    assign w_slot = (r_depth < gdw_pkg::DEPTH_W'(gdw_pkg::TRAIL_MAX)) ?
                    r_depth[gdw_pkg::TRAIL_AW-1:0] : gdw_pkg::TRAIL_AW'(gdw_pkg::TRAIL_MAX - 1);

    assign busy         = (r_state != gdw_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_walker_row = r_row;
    assign o_walker_col = r_col;
    assign o_step_count = r_count;
    assign o_status     = r_status;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdw_pkg::ST_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) n_state = gdw_pkg::ST_IDLE;
            end
            gdw_pkg::ST_IDLE: begin
                if (w_accept && i_command == gdw_pkg::CMD_STEP && w_can_step)
                    n_state = gdw_pkg::ST_ISSUE;
            end
            gdw_pkg::ST_ISSUE:  n_state = gdw_pkg::ST_EVAL;
            gdw_pkg::ST_EVAL: begin
                n_state = (r_k == 3'd7) ? gdw_pkg::ST_DECIDE : gdw_pkg::ST_ISSUE;
            end
            gdw_pkg::ST_DECIDE: begin
                if (w_any || r_depth <= gdw_pkg::DEPTH_W'(1)) n_state = gdw_pkg::ST_IDLE;
                else n_state = gdw_pkg::ST_LOAD;
            end
            gdw_pkg::ST_LOAD:   n_state = gdw_pkg::ST_IDLE;
            default:            n_state = gdw_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_row = r_row; n_col = r_col; n_count = r_count; n_depth = r_depth;
        n_no_route = r_no_route; n_valid = 1'b0; n_status = r_status;
        n_clr = r_clr; n_k = r_k; n_tgt_k = r_tgt_k; n_free_k = r_free_k;
        n_tgt_hit = r_tgt_hit; n_free_hit = r_free_hit; n_nb_in = r_nb_in;
        w_grid_we = 1'b0; w_grid_waddr = r_clr; w_grid_wdata = gdw_pkg::KIND_OPEN;
        w_grid_raddr = cell_addr(w_nr[6:0], w_nc[6:0]);
        w_trail_we = 1'b0; w_trail_waddr = w_slot;
        w_trail_wdata = {w_mr[6:0], w_mc[6:0], w_inc};
        w_trail_raddr = gdw_pkg::TRAIL_AW'(r_depth - gdw_pkg::DEPTH_W'(2));
        unique case (r_state)
            gdw_pkg::ST_CLEAR: begin
                w_grid_we = 1'b1;
                n_clr     = r_clr + 1'b1;
            end
            gdw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_status = gdw_pkg::STAT_ACK;
                    n_valid  = 1'b1;
                    case (i_command)
                        gdw_pkg::CMD_WRITE: begin
                            w_grid_we    = w_cell_in;
                            w_grid_waddr = cell_addr(i_cell_row, i_cell_col);
                            w_grid_wdata = i_cell_kind;
                        end
                        gdw_pkg::CMD_START: begin
                            n_row = 7'd1; n_col = r_start_col; n_count = '0;
                            n_no_route    = 1'b0;
                            n_depth       = gdw_pkg::DEPTH_W'(1);
                            w_trail_we    = 1'b1;
                            w_trail_waddr = '0;
                            w_trail_wdata = {7'd1, r_start_col, {gdw_pkg::CNT_W{1'b0}}};
                        end
                        gdw_pkg::CMD_STEP: begin
                            if (w_can_step) begin
                                // mark own cell visited, then scan
                                n_valid      = 1'b0;
                                w_grid_we    = w_walker_in;
                                w_grid_waddr = cell_addr(r_row, r_col);
                                w_grid_wdata = gdw_pkg::KIND_VISITED;
                                n_k = '0; n_tgt_hit = 1'b0; n_free_hit = 1'b0;
                            end else begin
                                n_no_route = 1'b1;
                                n_status   = gdw_pkg::STAT_NO_ROUTE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            gdw_pkg::ST_ISSUE: begin
                n_nb_in = w_nb_in;
            end
            gdw_pkg::ST_EVAL: begin
                // keep the first target and the first free neighbour
                if (w_kind == gdw_pkg::KIND_TARGET && !r_tgt_hit) begin
                    n_tgt_hit = 1'b1; n_tgt_k = r_k;
                end
                if (w_kind != gdw_pkg::KIND_WALL && w_kind != gdw_pkg::KIND_VISITED
                        && !r_free_hit) begin
                    n_free_hit = 1'b1; n_free_k = r_k;
                end
                n_k = r_k + 1'b1;
            end
            gdw_pkg::ST_DECIDE: begin
                if (w_any) begin
                    n_row = w_mr[6:0]; n_col = w_mc[6:0]; n_count = w_inc;
                    w_trail_we = 1'b1;
                    n_depth    = {1'b0, w_slot} + 1'b1;
                    n_status   = r_tgt_hit ? gdw_pkg::STAT_TARGET : gdw_pkg::STAT_OPEN;
                    n_valid    = 1'b1;
                end else if (r_depth <= gdw_pkg::DEPTH_W'(1)) begin
                    n_depth = '0; n_no_route = 1'b1;
                    n_status = gdw_pkg::STAT_NO_ROUTE;
                    n_valid  = 1'b1;
                end else begin
                    n_depth = r_depth - 1'b1;
                end
            end
            gdw_pkg::ST_LOAD: begin
                n_row    = r_trail_rd[SW-1 -: 7];
                n_col    = r_trail_rd[SW-8 -: 7];
                n_count  = r_trail_rd[gdw_pkg::CNT_W-1:0];
                n_status = gdw_pkg::STAT_BACK;
                n_valid  = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdw_pkg::ST_CLEAR;
            r_clr <= '0; r_row <= 7'd1; r_col <= 7'd1; r_count <= '0;
            r_depth <= '0; r_no_route <= 1'b0; r_valid <= 1'b0;
            r_status <= gdw_pkg::STAT_ACK; r_start_col <= 7'd1;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr; r_row <= n_row; r_col <= n_col; r_count <= n_count;
            r_depth <= n_depth; r_no_route <= n_no_route; r_valid <= n_valid;
            r_status <= n_status;
            if (i_cfg_we) r_start_col <= i_cfg_data;
        end
    end

    // scan registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_tgt_k <= n_tgt_k; r_free_k <= n_free_k;
        r_tgt_hit <= n_tgt_hit; r_free_hit <= n_free_hit; r_nb_in <= n_nb_in;
    end

    // grid memory
    always_ff @(posedge i_clk) begin
        if (w_grid_we) grid_mem[w_grid_waddr] <= w_grid_wdata;
        r_grid_rd <= grid_mem[w_grid_raddr];
    end

    // trail memory
    always_ff @(posedge i_clk) begin
        if (w_trail_we) trail_mem[w_trail_waddr] <= w_trail_wdata;
        r_trail_rd <= trail_mem[w_trail_raddr];
    end

    `CHK_CLK(a_valid_idle, o_valid |-> !busy, "result beat while busy")
    `CHK_CLK(a_accept_ack, (start && !busy) |=> (busy || o_valid), "command dropped")
    `CHK_CLK(a_no_route_empty, r_no_route |-> (r_depth == '0), "no route with trail")
    `CHK_CLK(a_depth_max, r_depth <= gdw_pkg::DEPTH_W'(gdw_pkg::TRAIL_MAX),
        "trail depth overrun")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for grid_dfs_walker: random and directed commands
// against a predictor of the depth-first walk. Depends on gdw_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [6:0]  row;
    logic [6:0]  col;
    logic [13:0] count;
    logic [2:0]  status;
} t_walk_beat;

class walk_scoreboard;
    logic [1:0]  grid [0:16383];
    logic [6:0]  trail_r [0:gdw_pkg::TRAIL_MAX-1];
    logic [6:0]  trail_c [0:gdw_pkg::TRAIL_MAX-1];
    logic [13:0] trail_n [0:gdw_pkg::TRAIL_MAX-1];
    int unsigned depth;
    int          wrow, wcol;
    logic [13:0] wcount;
    bit          no_route;
    logic [6:0]  start_col;
    t_walk_beat  pending[$];
    int          errors;

    function void clear();
        foreach (grid[i]) grid[i] = gdw_pkg::KIND_OPEN;
        depth = 0; wrow = 1; wcol = 1; wcount = '0; no_route = 0;
        start_col = 7'd1; errors = 0;
    endfunction

    function int nb_off_r(int k);
        case (k)
            0, 1, 7: return -1;
            2, 6:    return 0;
            default: return 1;
        endcase
    endfunction

    function int nb_off_c(int k);
        case (k)
            0, 4:    return 0;
            1, 2, 3: return 1;
            default: return -1;
        endcase
    endfunction

    function logic [1:0] kind_at(int r, int c);
        if (r < 0 || c < 0 || r > 127 || c > 127) return gdw_pkg::KIND_WALL;
        return grid[r*128 + c];
    endfunction

    function void push_trail(int r, int c, logic [13:0] n);
        int unsigned slot;
        slot = (depth < gdw_pkg::TRAIL_MAX) ? depth : gdw_pkg::TRAIL_MAX - 1;
        trail_r[slot] = 7'(r); trail_c[slot] = 7'(c); trail_n[slot] = n;
        depth = slot + 1;
    endfunction

    function logic [2:0] walk_step();
        int pick, r, c;
        logic [2:0] st;
        logic [1:0] v;
        pick = -1; st = gdw_pkg::STAT_ACK; r = wrow; c = wcol;
        if (depth == 0 || no_route) begin
            no_route = 1;
            return gdw_pkg::STAT_NO_ROUTE;
        end
        grid[r*128 + c] = gdw_pkg::KIND_VISITED;
        for (int k = 0; k < 8 && pick < 0; k++)
            if (kind_at(r + nb_off_r(k), c + nb_off_c(k)) == gdw_pkg::KIND_TARGET) begin
                pick = k; st = gdw_pkg::STAT_TARGET;
            end
        for (int k = 0; k < 8 && pick < 0; k++) begin
            v = kind_at(r + nb_off_r(k), c + nb_off_c(k));
            if (v != gdw_pkg::KIND_WALL && v != gdw_pkg::KIND_VISITED) begin
                pick = k; st = gdw_pkg::STAT_OPEN;
            end
        end
        if (pick >= 0) begin
            wrow = r + nb_off_r(pick); wcol = c + nb_off_c(pick);
            if (wcount != gdw_pkg::COUNT_MAX) wcount++;
            push_trail(wrow, wcol, wcount);
            return st;
        end
        if (depth <= 1) begin
            depth = 0; no_route = 1;
            return gdw_pkg::STAT_NO_ROUTE;
        end
        depth--;
        wrow = int'(trail_r[depth-1]); wcol = int'(trail_c[depth-1]);
        wcount = trail_n[depth-1];
        return gdw_pkg::STAT_BACK;
    endfunction

    // Note one accepted command and queue the beat it must produce
    function void note_command(logic [1:0] cmd, logic [6:0] r, logic [6:0] c,
                               logic [1:0] kind);
        t_walk_beat b;
        b.status = gdw_pkg::STAT_ACK;
        if (cmd == gdw_pkg::CMD_WRITE) grid[r*128 + c] = kind;
        else if (cmd == gdw_pkg::CMD_START) begin
            wrow = 1; wcol = int'(start_col); wcount = '0; no_route = 0; depth = 0;
            push_trail(1, int'(start_col), 14'd0);
        end else if (cmd == gdw_pkg::CMD_STEP) b.status = walk_step();
        b.row = 7'(wrow); b.col = 7'(wcol); b.count = wcount;
        pending.push_back(b);
    endfunction

    function void check_beat(t_walk_beat got);
        t_walk_beat e;
        if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.row !== e.row) begin
            $error("walker_row expected %0d actual %0d", e.row, got.row); errors++;
        end
        if (got.col !== e.col) begin
            $error("walker_col expected %0d actual %0d", e.col, got.col); errors++;
        end
        if (got.count !== e.count) begin
            $error("step_count expected %0d actual %0d", e.count, got.count); errors++;
        end
        if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status); errors++;
        end
    endfunction
endclass

module tb_top;
    logic        i_clk = 0, i_rst_n = 0, start = 0, i_cfg_we = 0;
    logic [1:0]  i_command = 0, i_cell_kind = 0;
    logic [6:0]  i_cell_row = 0, i_cell_col = 0, i_cfg_data = 1;
    logic        busy, o_valid;
    logic [6:0]  o_walker_row, o_walker_col;
    logic [13:0] o_step_count;
    logic [2:0]  o_status;
    walk_scoreboard sb;
    bit          calm;
    int          sent;

    grid_dfs_walker u_dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Take every result beat in its one cycle
    always @(posedge i_clk)
        if (i_rst_n && o_valid)
            sb.check_beat('{o_walker_row, o_walker_col, o_step_count, o_status});

    // Drive one command and hold it until the block takes it; start stays
    // high after the beat so that the next command can follow at once
    task automatic send(logic [1:0] cmd, logic [6:0] r = '0, logic [6:0] c = '0,
                        logic [1:0] kind = '0);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            i_command <= 2'($urandom); i_cell_row <= 7'($urandom);
            i_cell_col <= 7'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        start <= 1'b1; i_command <= cmd; i_cell_row <= r; i_cell_col <= c;
        i_cell_kind <= kind;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, r, c, kind);
        sent++;
    endtask

    // Drop start and wait for every beat in flight
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic set_start_col(logic [6:0] v);
        i_cfg_we <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.start_col = v;
    endtask

    // Random walls, targets and open cells in a small window around the start
    task automatic build_maze(logic [6:0] sc);
        int r, c;
        repeat ($urandom_range(4, 14)) begin
            r = $urandom_range(0, 5);
            c = int'(sc) + $urandom_range(0, 8) - 4;
            if (c < 0 || c > 127) c = int'(sc);
            send(gdw_pkg::CMD_WRITE, 7'(r), 7'(c),
                 ($urandom_range(0, 5) == 0) ? gdw_pkg::KIND_TARGET :
                 ($urandom_range(0, 1) ? gdw_pkg::KIND_WALL : gdw_pkg::KIND_OPEN));
        end
    endtask

    initial begin
        logic [6:0] sc;
        sb = new();
        sb.clear();
        sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty-trail step, unused command, edge columns, extremes
        send(gdw_pkg::CMD_STEP);
        send(gdw_pkg::CMD_SPARE, 7'h7f, 7'h7f, gdw_pkg::KIND_TARGET);
        send(gdw_pkg::CMD_WRITE, 7'h7f, 7'h7f, gdw_pkg::KIND_TARGET);
        send(gdw_pkg::CMD_WRITE, 7'h7f, 7'h7f, gdw_pkg::KIND_OPEN);
        send(gdw_pkg::CMD_WRITE, 7'd0, 7'd0, gdw_pkg::KIND_VISITED);
        send(gdw_pkg::CMD_START);
        repeat (6) send(gdw_pkg::CMD_STEP);
        drain();
        set_start_col(7'd126);
        send(gdw_pkg::CMD_WRITE, 7'd0, 7'd127, gdw_pkg::KIND_TARGET);
        send(gdw_pkg::CMD_START);
        repeat (3) send(gdw_pkg::CMD_STEP);
        drain();
        set_start_col(7'd1);
        // Boxed start cell: no route at once
        for (int k = 0; k < 8; k++)
            send(gdw_pkg::CMD_WRITE, 7'(1 + sb.nb_off_r(k)), 7'(1 + sb.nb_off_c(k)),
                 gdw_pkg::KIND_WALL);
        send(gdw_pkg::CMD_START);
        send(gdw_pkg::CMD_STEP);
        send(gdw_pkg::CMD_STEP);
        drain();

        while (sent < 1100) begin
            calm = sent > 950;
            sc = 7'($urandom_range(1, 126));
            if ($urandom_range(0, 3) == 0) sc = $urandom_range(0, 1) ? 7'd1 : 7'd126;
            if ($urandom_range(0, 9) == 0) begin
                send(gdw_pkg::CMD_WRITE, 7'($urandom), 7'($urandom), 2'($urandom));
                send(2'($urandom), 7'($urandom), 7'($urandom), 2'($urandom));
            end
            drain();
            set_start_col(sc);
            build_maze(sc);
            send(gdw_pkg::CMD_START);
            repeat ($urandom_range(5, 40)) send(gdw_pkg::CMD_STEP);
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gdw_pkg.sv
hdl/grid_dfs_walker.sv
sim/tb_top.sv
